@@ design/ansi_pkg.sv @@
// Shared types and constants for the terminal escape stripper.
package ansi_pkg;

    localparam int CNT_W              = 10;
    localparam int FIFO_DEPTH_DEFAULT = 4;
    localparam int JOB_BYTES          = 3;

    localparam logic [CNT_W-1:0] MAX_LEN_RESET = 10'd1023;

    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0d;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI,
        MODE_TILDE,
        MODE_TDOLL
    } scan_mode_t;

    // Work for the back end from one input byte: up to three candidate
    // bytes in order, then an end marker if the message closed.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [1:0]                nbytes;
        logic                      last;
    } job_t;

endpackage

@@ design/ansi_stream_if.sv @@
// Valid/ready stream interfaces for the input bytes and the results.
interface ansi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface ansi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       end_marker;
    logic [9:0] out_count;

    modport source (output valid, output char_out, output end_marker, output out_count,
                    input ready);
    modport sink   (input valid, input char_out, input end_marker, input out_count,
                    output ready);
endinterface

@@ design/ansi_front.sv @@
// Front end: scan state machine that turns each input byte into a job.
module ansi_front (
    input  logic           clk,
    input  logic           rst_n,
    ansi_in_if.sink        in_ch,
    input  logic           q_full,
    output logic           q_push,
    output ansi_pkg::job_t q_job
);
    import ansi_pkg::*;

    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    job_t       job;
    logic       accept;

    function automatic job_t add_byte(job_t j, logic [7:0] x);
        job_t r;
        r = j;
        case (j.nbytes)
            2'd0:    r.bytes[0] = x;
            2'd1:    r.bytes[1] = x;
            default: r.bytes[2] = x;
        endcase
        r.nbytes = j.nbytes + 2'd1;
        return r;
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        logic plain;
        plain     = 1'b0;
        mode_next = mode_reg;
        job       = '0;
        job.last  = in_ch.last_in;

        case (mode_reg)
            MODE_ESC:
            begin
                if (in_ch.char_in == CH_LBRK)
                    mode_next = MODE_CSI;
                else
                    plain = 1'b1;
            end
            MODE_CSI:
            begin
                if (in_ch.char_in inside {[CH_AT:CH_TILDE]})
                    mode_next = MODE_NORMAL;
            end
            MODE_TILDE:
            begin
                if (in_ch.char_in == CH_DOLLAR)
                    mode_next = MODE_TDOLL;
                else
                begin
                    job   = add_byte(job, CH_TILDE);
                    plain = 1'b1;
                end
            end
            MODE_TDOLL:
            begin
                mode_next = MODE_NORMAL;
                if (in_ch.char_in != CH_SPACE)
                begin
                    job   = add_byte(job, CH_TILDE);
                    job   = add_byte(job, CH_DOLLAR);
                    plain = 1'b1;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        if (plain)
        begin
            mode_next = MODE_NORMAL;
            if (in_ch.char_in == CH_ESC)
                mode_next = MODE_ESC;
            else if (in_ch.char_in == CH_TILDE)
                mode_next = MODE_TILDE;
            else if (in_ch.char_in != CH_CR)
                job = add_byte(job, in_ch.char_in);
        end

        // Message end: replay any held prompt prefix, drop a pending escape.
        if (in_ch.last_in)
        begin
            if (mode_next == MODE_TILDE)
                job = add_byte(job, CH_TILDE);
            else if (mode_next == MODE_TDOLL)
            begin
                job = add_byte(job, CH_TILDE);
                job = add_byte(job, CH_DOLLAR);
            end
            mode_next = MODE_NORMAL;
        end
    end

    // Drop bytes that produce nothing instead of queueing an empty job.
    assign q_push = accept && ((job.nbytes != 2'd0) || job.last);
    assign q_job  = job;

endmodule

@@ design/ansi_fifo.sv @@
// Short job queue between the front and back ends.
module ansi_fifo #(
    parameter int DEPTH = ansi_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ansi_pkg::job_t push_job,
    input  logic           pop,
    output ansi_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);
    import ansi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    job_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] fill_reg;
    logic               do_push;
    logic               do_pop;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CNT_W_Q'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

@@ design/ansi_back.sv @@
// Back end: walks each job, applies the length limit and drives results.
module ansi_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ansi_pkg::CNT_W-1:0] max_len,
    input  ansi_pkg::job_t           job,
    input  logic                     q_empty,
    output logic                     q_pop,
    ansi_out_if.source               out_ch
);
    import ansi_pkg::*;

    logic [1:0]       pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic [7:0]       char_reg;
    logic             end_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             step;
    logic             is_byte;
    logic             last_slot;
    logic             keep;
    logic [7:0]       cur_byte;
    logic [CNT_W-1:0] count_inc;

    assign is_byte   = pos_reg < job.nbytes;
    assign last_slot = is_byte ? (!job.last && (pos_reg == job.nbytes - 2'd1)) : 1'b1;
    assign step      = !q_empty && (!out_valid_reg || out_ch.ready);
    assign keep      = count_reg < max_len;
    assign count_inc = count_reg + 1'b1;
    assign q_pop     = step && last_slot;

    always_comb
    begin
        case (pos_reg)
            2'd0:    cur_byte = job.bytes[0];
            2'd1:    cur_byte = job.bytes[1];
            default: cur_byte = job.bytes[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
                pos_reg <= last_slot ? 2'd0 : pos_reg + 2'd1;
            // Load a new result, or drop the old one once it has been taken.
            if (step && (!is_byte || keep))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (step && !is_byte)
                count_reg <= '0;
            else if (step && keep)
                count_reg <= count_inc;
        end
    end

    // Result payload: load with each emitted result.
    always_ff @(posedge clk)
    begin
        if (step && (!is_byte || keep))
        begin
            char_reg      <= is_byte ? cur_byte : 8'd0;
            end_reg       <= !is_byte;
            out_count_reg <= is_byte ? count_inc : count_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.char_out   = char_reg;
    assign out_ch.end_marker = end_reg;
    assign out_ch.out_count  = out_count_reg;

endmodule

@@ design/ansi_escape_stripper.sv @@
// Top level of the terminal escape stripper: front end, job queue, back end.
//
//   port      | dir | transfer when        | carries
//   ----------+-----+----------------------+-------------------------------------
//   in_ch     | in  | valid && ready       | char_in[7:0], last_in
//   out_ch    | out | valid && ready       | char_out[7:0], end_marker, out_count[9:0]
//   cfg_we    | in  | cfg_we high          | cfg_data[9:0] -> max_length
//
// The front end takes one byte per cycle while the job queue (FIFO_DEPTH entries)
// has room. The back end walks the candidate results of a job in order: each kept or
// limit-dropped byte, then the end marker, so a job holds 1 to 4 candidates.
// Results leave through a single output register; a stalled output holds the back
// end while the front keeps filling the queue. Reset returns the scanner to normal
// mode, clears the count and the queue, and sets max_length to 1023.
module ansi_escape_stripper #(
    parameter int FIFO_DEPTH = ansi_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ansi_in_if.sink                    in_ch,
    ansi_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [ansi_pkg::CNT_W-1:0] cfg_data
);
    import ansi_pkg::*;

    logic [CNT_W-1:0] max_len_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    job_t             push_job;
    job_t             head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_data;
    end

    ansi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    ansi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    ansi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .max_len (max_len_reg),
        .job     (head_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

`ifndef SYNTH
    // A kept byte never pushes the count past the limit and never reports zero.
    a_byte_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.end_marker) |->
            (out_ch.out_count != '0 && out_ch.out_count <= max_len_reg))
        else $error("byte result count outside 1..max_length");

    // Consecutive byte results of one message count up by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.end_marker) |=>
            (!out_ch.valid || out_ch.end_marker ||
             out_ch.out_count == $past(out_ch.out_count) + 10'd1))
        else $error("byte count did not advance by one");

    // The end marker carries no byte.
    a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.end_marker) |-> (out_ch.char_out == 8'd0))
        else $error("end marker carries a byte");
`endif

endmodule

@@ sim/ansi_strip_check.sv @@
// Checker for the escape stripper: predicts results from input transfers and compares outputs.
module ansi_strip_check (
    input  logic                       clk,
    input  logic                       rst_n,
    ansi_in_if                         in_mon,
    ansi_out_if                        out_mon,
    input  logic                       cfg_we,
    input  logic [ansi_pkg::CNT_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         pending_count
);
    import ansi_pkg::*;

    typedef struct packed {
        logic [7:0]       ch;
        logic             fin;
        logic [CNT_W-1:0] cnt;
    } strip_result_t;

    strip_result_t    expected_out[$];
    scan_mode_t       scan_state;
    logic [CNT_W-1:0] kept_count;
    logic [CNT_W-1:0] max_len;

    function automatic void keep_byte(input logic [7:0] ch);
        // Drop the byte once the message has reached its limit.
        if (kept_count < max_len)
        begin
            kept_count = kept_count + 1'b1;
            expected_out.push_back(strip_result_t'{ch, 1'b0, kept_count});
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] ch);
        if (ch == CH_ESC)
            scan_state = MODE_ESC;
        else if (ch == CH_TILDE)
            scan_state = MODE_TILDE;
        else if (ch != CH_CR)
            keep_byte(ch);
    endfunction

    function automatic void strip_byte(input logic [7:0] ch, input logic lst);
        case (scan_state)
            MODE_ESC:
            begin
                scan_state = MODE_NORMAL;
                if (ch == CH_LBRK)
                    scan_state = MODE_CSI;
                else
                    plain_byte(ch);
            end
            MODE_CSI:
            begin
                if (ch >= CH_AT && ch <= CH_TILDE)
                    scan_state = MODE_NORMAL;
            end
            MODE_TILDE:
            begin
                if (ch == CH_DOLLAR)
                    scan_state = MODE_TDOLL;
                else
                begin
                    scan_state = MODE_NORMAL;
                    keep_byte(CH_TILDE);
                    plain_byte(ch);
                end
            end
            MODE_TDOLL:
            begin
                scan_state = MODE_NORMAL;
                if (ch != CH_SPACE)
                begin
                    keep_byte(CH_TILDE);
                    keep_byte(CH_DOLLAR);
                    plain_byte(ch);
                end
            end
            default:
            begin
                scan_state = MODE_NORMAL;
                plain_byte(ch);
            end
        endcase

        if (lst)
        begin
            // Replay a held prompt prefix, then close the message.
            if (scan_state == MODE_TILDE)
                keep_byte(CH_TILDE);
            else if (scan_state == MODE_TDOLL)
            begin
                keep_byte(CH_TILDE);
                keep_byte(CH_DOLLAR);
            end
            expected_out.push_back(strip_result_t'{8'h00, 1'b1, kept_count});
            scan_state = MODE_NORMAL;
            kept_count = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        strip_result_t want;
        if (!rst_n)
        begin
            scan_state = MODE_NORMAL;
            kept_count = '0;
            max_len = MAX_LEN_RESET;
            expected_out.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_data;
            if (in_mon.valid && in_mon.ready)
                strip_byte(in_mon.char_in, in_mon.last_in);
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected result char %02h end %0b count %0d", $time,
                             out_mon.char_out, out_mon.end_marker, out_mon.out_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_mon.char_out !== want.ch || out_mon.end_marker !== want.fin ||
                        out_mon.out_count !== want.cnt)
                    begin
                        $display({"%0t: expected char %02h end %0b count %0d,",
                                  " got char %02h end %0b count %0d"},
                                 $time, want.ch, want.fin, want.cnt,
                                 out_mon.char_out, out_mon.end_marker, out_mon.out_count);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_out.size();
    end

endmodule

@@ sim/tb_ansi_escape_stripper.sv @@
// Testbench top for the escape stripper: clock, reset, stimulus, stalls and verdict.
module tb_ansi_escape_stripper;
    import ansi_pkg::*;

    localparam int SETTLE    = 40;
    localparam int LONG_HOLD = 80;

    typedef logic [7:0] byte_q_t[$];

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_seen;
    int hold_left;
    int mismatch_count;
    int pending_count;

    ansi_in_if  in_bus();
    ansi_out_if out_bus();

    ansi_escape_stripper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_bus),
        .out_ch   (out_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    ansi_strip_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_bus),
        .out_mon        (out_bus),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls plus an occasional long hold-off on request.
    initial
    begin
        out_bus.ready <= 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.char_in <= ch;
        in_bus.last_in <= lst;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
    endtask

    task automatic send_message(input byte_q_t msg);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Hold the input, wait for every expected result, then let the back end settle.
    task automatic drain(input int settle);
        in_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (settle)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_max_len(input logic [CNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Build one message from a mix of CSI sequences, prompts, text and noise.
    task automatic random_message(output int len);
        byte_q_t msg;
        int      tokens;
        tokens = $urandom_range(1, 6);
        repeat (tokens)
        begin
            case ($urandom_range(9))
                0: msg.push_back(8'($urandom_range(255)));
                1:
                begin
                    msg.push_back(CH_ESC);
                    msg.push_back(CH_LBRK);
                    repeat ($urandom_range(3))
                        msg.push_back(8'($urandom_range(8'h30, 8'h3f)));
                    msg.push_back(8'($urandom_range(CH_AT, CH_TILDE)));
                end
                2:
                begin
                    msg.push_back(CH_TILDE);
                    msg.push_back(CH_DOLLAR);
                    msg.push_back(CH_SPACE);
                end
                3:
                begin
                    msg.push_back(CH_TILDE);
                    msg.push_back(8'($urandom_range(255)));
                end
                4:
                begin
                    msg.push_back(CH_TILDE);
                    msg.push_back(CH_DOLLAR);
                    msg.push_back(8'($urandom_range(255)));
                end
                5: msg.push_back(CH_CR);
                6:
                begin
                    msg.push_back(CH_ESC);
                    msg.push_back(8'($urandom_range(255)));
                end
                default: msg.push_back(8'($urandom_range(8'h20, 8'h7e)));
            endcase
        end
        len = msg.size();
        send_message(msg);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] limit, input int target, input bit pressure);
        int sent;
        int len;
        sent = 0;
        write_max_len(limit);
        if (pressure)
            hold_asks <= hold_asks + 1;
        while (sent < target)
        begin
            random_message(len);
            sent += len;
            // Pause the sender once until the back end has caught up.
            if (pressure && sent >= target / 2 && sent - len < target / 2)
                drain(0);
        end
        drain(SETTLE);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.char_in <= 8'h00;
        in_bus.last_in <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_data       <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, CR, CSI, lone ESC, prompt and its partial matches,
        // CSI ending in a tilde, held prompt prefixes and open sequences at message end.
        send_message('{8'h00, 8'hff, CH_CR, CH_ESC, CH_LBRK, "1", "m", CH_ESC, "x",
                       CH_TILDE, CH_DOLLAR, CH_SPACE, CH_TILDE, "q",
                       CH_TILDE, CH_DOLLAR, "z", CH_ESC, CH_LBRK, CH_TILDE, CH_TILDE});
        send_message('{CH_TILDE, CH_DOLLAR});
        send_message('{CH_ESC, CH_LBRK});
        send_message('{CH_ESC});
        drain(SETTLE);

        send_idle_pct  <= 10;
        recv_stall_pct <= 52;
        run_phase(10'd5, 60, 1'b0);
        run_phase(10'd0, 20, 1'b0);

        send_idle_pct  <= 52;
        recv_stall_pct <= 10;
        run_phase(10'd1023, 80, 1'b0);
        run_phase(10'd12, 60, 1'b0);

        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        run_phase(10'd3, 60, 1'b1);
        run_phase(10'd1023, 50, 1'b0);

        if (mismatch_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/ansi_pkg.sv
design/ansi_stream_if.sv
design/ansi_front.sv
design/ansi_fifo.sv
design/ansi_back.sv
design/ansi_escape_stripper.sv
sim/ansi_strip_check.sv
sim/tb_ansi_escape_stripper.sv
